### sv/sctt_pkg.sv
// ----------------------------------------------------------------------------
// sctt_pkg
// Shared types and constants for the Taylor-series sine/cosine/tangent block.
// ----------------------------------------------------------------------------
package sctt_pkg;

  // field widths
  localparam int VAL_W   = 40;
  localparam int ANG_W   = 32;
  localparam int TOL_W   = 31;
  localparam int OP_W    = 2;
  localparam int CNT_W   = 11;
  localparam int CFG_W   = 10;
  localparam int CHUNK_W = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 10'd1000;

  // operation codes
  localparam logic [OP_W-1:0] OP_SIN  = 2'd0;
  localparam logic [OP_W-1:0] OP_COS  = 2'd1;
  localparam logic [OP_W-1:0] OP_TAN  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  // multiplier operand source
  localparam logic MSRC_MAG = 1'b0;
  localparam logic MSRC_QUO = 1'b1;

  // divider operand source
  localparam logic [1:0] DSRC_D1  = 2'd0;
  localparam logic [1:0] DSRC_D2  = 2'd1;
  localparam logic [1:0] DSRC_TAN = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_M1L, S_M1R, S_D1L, S_D1R, S_M2L, S_M2R,
    S_D2L, S_D2R, S_UPD, S_TDL, S_TDR, S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       init;
    logic       cos_sel;
    logic       save_sin;
    logic       mul_load;
    logic       mul_src;
    logic       mul_run;
    logic       div_load;
    logic [1:0] div_src;
    logic       div_run;
    logic       update;
    logic       out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            mul_done;
    logic            div_done;
    logic            stop;
    logic            at_limit;
  } stat_t;

endpackage

### sv/sctt_ctrl.sv
// ----------------------------------------------------------------------------
// sctt_ctrl
// Sequencer: steps each series term through multiply, divide, multiply,
// divide and update, runs the second series and the quotient for tangent.
// ----------------------------------------------------------------------------
module sctt_ctrl import sctt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic   cos_phase;
  logic   series_end;

  assign series_end = stat.stop || stat.at_limit;

  // state register, tangent phase, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cos_phase <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        cos_phase <= 1'b0;
      end else if (cmd.save_sin) begin
        cos_phase <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_INIT;
      S_INIT: state_next = (stat.op == OP_NONE) ? S_DONE : S_M1L;
      S_M1L:  state_next = S_M1R;
      S_M1R:  if (stat.mul_done) state_next = S_D1L;
      S_D1L:  state_next = S_D1R;
      S_D1R:  if (stat.div_done) state_next = S_M2L;
      S_M2L:  state_next = S_M2R;
      S_M2R:  if (stat.mul_done) state_next = S_D2L;
      S_D2L:  state_next = S_D2R;
      S_D2R:  if (stat.div_done) state_next = S_UPD;
      S_UPD: begin
        if (!series_end) begin
          state_next = S_M1L;
        end else if (stat.op == OP_TAN && !cos_phase) begin
          state_next = S_INIT;
        end else if (stat.op == OP_TAN) begin
          state_next = S_TDL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_TDL:  state_next = S_TDR;
      S_TDR:  if (stat.div_done) state_next = S_DONE;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd         = '0;
    cmd.cos_sel = (stat.op == OP_COS) || cos_phase;
    in_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_INIT: cmd.init = (stat.op != OP_NONE);
      S_M1L: begin
        cmd.mul_load = 1'b1;
        cmd.mul_src  = MSRC_MAG;
      end
      S_M2L: begin
        cmd.mul_load = 1'b1;
        cmd.mul_src  = MSRC_QUO;
      end
      S_M1R, S_M2R: cmd.mul_run = 1'b1;
      S_D1L: begin
        cmd.div_load = 1'b1;
        cmd.div_src  = DSRC_D1;
      end
      S_D2L: begin
        cmd.div_load = 1'b1;
        cmd.div_src  = DSRC_D2;
      end
      S_TDL: begin
        cmd.div_load = 1'b1;
        cmd.div_src  = DSRC_TAN;
      end
      S_D1R, S_D2R, S_TDR: cmd.div_run = 1'b1;
      S_UPD: begin
        cmd.update   = 1'b1;
        cmd.save_sin = series_end && (stat.op == OP_TAN) && !cos_phase;
      end
      S_DONE: cmd.out_load = !out_valid || out_ready;
      default: cmd = '0;
    endcase
  end

endmodule

### sv/sctt_dp.sv
// ----------------------------------------------------------------------------
// sctt_dp
// Datapath: term magnitude, running sum, chunked multiplier, two-bit-per-cycle
// restoring divider, tangent quotient and the result register.
// ----------------------------------------------------------------------------
module sctt_dp import sctt_pkg::*; #(
  parameter int FRAC_BITS      = 28,
  parameter int MAX_TERM_LIMIT = 1023
) (
  input  logic                    clk,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  logic [OP_W-1:0]         operation,
  input  logic signed [ANG_W-1:0] angle,
  input  logic [TOL_W-1:0]        tolerance,
  input  logic [CFG_W-1:0]        limit_cfg,
  output logic signed [VAL_W-1:0] value,
  output logic [CNT_W-1:0]        term_count,
  output logic                    saturated,
  output logic                    limit_reached
);

  localparam int W1W      = VAL_W + ANG_W - FRAC_BITS;
  localparam int MCW      = (W1W > VAL_W) ? W1W : VAL_W;
  localparam int NCH      = (MCW + CHUNK_W - 1) / CHUNK_W;
  localparam int MCP      = NCH * CHUNK_W;
  localparam int ACW      = MCP + ANG_W;
  localparam int SHW      = ACW - FRAC_BITS;
  localparam int SDW      = (SHW < 64) ? SHW : 64;
  localparam int SER_BITS = SDW + (SDW % 2);
  localparam int TNW      = VAL_W + FRAC_BITS;
  localparam int TAN_BITS = TNW + (TNW % 2);
  localparam int DVW      = (SER_BITS > TAN_BITS) ? SER_BITS : TAN_BITS;
  localparam int DCW      = $clog2(DVW / 2 + 1);
  localparam int KW       = $clog2(MAX_TERM_LIMIT + 2);
  localparam int DW       = KW + 1;
  localparam int LW       = (KW > CFG_W) ? KW : CFG_W;
  localparam int MNW      = $clog2(NCH);
  localparam logic [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W:0]   SMAX = {2'b00, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W:0]   SMIN = {2'b11, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] TINT = VMAX >> FRAC_BITS;
  localparam bit               ONE_FITS = FRAC_BITS < VAL_W - 1;
  localparam logic [VAL_W-1:0] ONE_V = ONE_FITS ? (VAL_W'(1) << FRAC_BITS) : VMAX;
  localparam logic [DCW-1:0]   SER_LAST = DCW'(SER_BITS / 2 - 1);
  localparam logic [DCW-1:0]   TAN_LAST = DCW'(TAN_BITS / 2 - 1);

  // item registers
  logic [OP_W-1:0]         op;
  logic [ANG_W-1:0]        ax;
  logic signed [ANG_W-1:0] x;
  logic [TOL_W-1:0]        tol;
  logic [KW-1:0]           lim_eff;
  // series registers
  logic [KW-1:0]           k;
  logic [KW-1:0]           cnt;
  logic [VAL_W-1:0]        mag;
  logic                    neg;
  logic signed [VAL_W-1:0] sum;
  logic signed [VAL_W-1:0] s_save;
  logic                    sat;
  logic                    lim;
  logic                    ovf2;
  // multiplier
  logic [MCP-1:0]          mcand;
  logic [ACW-1:0]          acc;
  logic [MNW-1:0]          mcnt;
  logic                    ovf;
  // divider
  logic [DVW-1:0]          dvd;
  logic [VAL_W-1:0]        dsr;
  logic [VAL_W-1:0]        rem;
  logic [DVW-1:0]          quo;
  logic [DCW-1:0]          dcnt;
  logic [DCW-1:0]          dlast;

  // effective limit, clamped to 1..MAX_TERM_LIMIT
  logic [LW-1:0] lim_ext;
  logic [KW-1:0] lim_clamp;
  always_comb begin
    lim_ext = LW'(limit_cfg);
    if (lim_ext == '0) begin
      lim_clamp = KW'(1);
    end else if (lim_ext > LW'(MAX_TERM_LIMIT)) begin
      lim_clamp = KW'(MAX_TERM_LIMIT);
    end else begin
      lim_clamp = KW'(lim_ext);
    end
  end

  // factorial factors for the current iteration
  logic [DW-1:0] kk, d1, d2;
  assign kk = {k, 1'b0};
  assign d1 = cmd.cos_sel ? kk - DW'(1) : kk;
  assign d2 = cmd.cos_sel ? kk : kk + DW'(1);

  // product scaled back, with overflow of the 64-bit intermediate
  logic [SHW-1:0] shifted;
  assign shifted = acc[ACW-1:FRAC_BITS];
  generate
    if (SHW > 64) begin : g_ovf
      assign ovf = |shifted[SHW-1:64];
    end else begin : g_novf
      assign ovf = 1'b0;
    end
  endgenerate

  // magnitudes for the tangent quotient
  logic [VAL_W-1:0] ua, ub;
  assign ua = s_save[VAL_W-1] ? VAL_W'(-s_save) : VAL_W'(s_save);
  assign ub = sum[VAL_W-1] ? VAL_W'(-sum) : VAL_W'(sum);

  // two restoring divide steps
  logic [VAL_W:0]   t1, t0;
  logic             q1, q0;
  logic [VAL_W-1:0] r1, r0;
  always_comb begin
    t1 = {rem, dvd[DVW-1]};
    q1 = t1 >= {1'b0, dsr};
    r1 = q1 ? VAL_W'(t1 - {1'b0, dsr}) : t1[VAL_W-1:0];
    t0 = {r1, dvd[DVW-2]};
    q0 = t0 >= {1'b0, dsr};
    r0 = q0 ? VAL_W'(t0 - {1'b0, dsr}) : t0[VAL_W-1:0];
  end

  // term update: new magnitude, sign flip, saturating sum
  logic             big;
  logic [VAL_W-1:0] mag_new;
  logic [VAL_W:0]   term, s41;
  logic [VAL_W-1:0] sum_new;
  logic             sum_clip;
  always_comb begin
    big     = |quo[DVW-1:VAL_W-1];
    mag_new = (ovf2 || big) ? VMAX : quo[VAL_W-1:0];
    term    = neg ? {1'b0, mag_new} : -{1'b0, mag_new};
    s41     = {sum[VAL_W-1], sum} + term;
    sum_clip = 1'b1;
    if ($signed(s41) > $signed(SMAX)) begin
      sum_new = SMAX[VAL_W-1:0];
    end else if ($signed(s41) < $signed(SMIN)) begin
      sum_new = SMIN[VAL_W-1:0];
    end else begin
      sum_new  = s41[VAL_W-1:0];
      sum_clip = 1'b0;
    end
  end

  // tangent result
  logic [TNW-1:0]   qf;
  logic             qsat, czero;
  logic [VAL_W-1:0] qv, tval;
  always_comb begin
    qf    = quo[TNW-1:0];
    qsat  = qf[TNW-1:FRAC_BITS] > TINT;
    qv    = qsat ? VMAX : qf[VAL_W-1:0];
    czero = (sum == '0);
    if (czero) begin
      tval = s_save[VAL_W-1] ? -VMAX : VMAX;
    end else begin
      tval = (s_save[VAL_W-1] ^ sum[VAL_W-1]) ? -qv : qv;
    end
  end

  // status
  always_comb begin
    stat.op       = op;
    stat.mul_done = (mcnt == MNW'(NCH - 1));
    stat.div_done = (dcnt == dlast);
    stat.stop     = mag_new <= VAL_W'(tol);
    stat.at_limit = (k == lim_eff);
  end

  // item and series registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= operation;
      x       <= angle;
      ax      <= angle[ANG_W-1] ? ANG_W'(-angle) : ANG_W'(angle);
      tol     <= tolerance;
      lim_eff <= lim_clamp;
      sat     <= 1'b0;
      lim     <= 1'b0;
      cnt     <= '0;
    end
    if (cmd.init) begin
      k <= KW'(1);
      if (cmd.cos_sel) begin
        mag <= ONE_V;
        sum <= ONE_V;
        neg <= 1'b0;
        if (!ONE_FITS) sat <= 1'b1;
      end else begin
        mag <= VAL_W'(ax);
        sum <= VAL_W'(x);
        neg <= x[ANG_W-1];
      end
    end
    if (cmd.update) begin
      mag <= mag_new;
      neg <= !neg;
      sum <= sum_new;
      k   <= k + KW'(1);
      if (ovf2 || big || sum_clip) sat <= 1'b1;
      if (stat.stop) begin
        cnt <= k;
      end else if (stat.at_limit) begin
        cnt <= lim_eff + KW'(1);
        lim <= 1'b1;
      end
    end
    if (cmd.save_sin) s_save <= sum_new;
  end

  // chunked multiplier, most significant chunk first
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      mcand <= (cmd.mul_src == MSRC_QUO) ? MCP'(quo[W1W-1:0]) : MCP'(mag);
      acc   <= '0;
      mcnt  <= '0;
    end else if (cmd.mul_run) begin
      acc   <= (acc << CHUNK_W) + ACW'(mcand[MCP-1 -: CHUNK_W] * ax);
      mcand <= mcand << CHUNK_W;
      mcnt  <= mcnt + MNW'(1);
    end
  end

  // divider
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem  <= '0;
      quo  <= '0;
      dcnt <= '0;
      case (cmd.div_src)
        DSRC_TAN: begin
          dvd   <= DVW'({ua, {FRAC_BITS{1'b0}}}) << (DVW - TAN_BITS);
          dsr   <= ub;
          dlast <= TAN_LAST;
        end
        DSRC_D2: begin
          dvd   <= DVW'(shifted[SDW-1:0]) << (DVW - SER_BITS);
          dsr   <= VAL_W'(d2);
          dlast <= SER_LAST;
          ovf2  <= ovf;
        end
        default: begin
          dvd   <= DVW'(shifted[SDW-1:0]) << (DVW - SER_BITS);
          dsr   <= VAL_W'(d1);
          dlast <= SER_LAST;
        end
      endcase
    end else if (cmd.div_run) begin
      rem  <= r0;
      dvd  <= dvd << 2;
      quo  <= {quo[DVW-3:0], q1, q0};
      dcnt <= dcnt + DCW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      term_count    <= CNT_W'(cnt);
      limit_reached <= lim;
      case (op)
        OP_SIN, OP_COS: begin
          value     <= sum;
          saturated <= sat;
        end
        OP_TAN: begin
          value     <= tval;
          saturated <= sat || czero || qsat;
        end
        default: begin
          value     <= '0;
          saturated <= 1'b0;
        end
      endcase
    end
  end

endmodule

### sv/sin_cos_tan_taylor_series.sv
// ----------------------------------------------------------------------------
// sin_cos_tan_taylor_series
// Fixed-point sine, cosine and tangent by Taylor series, one term at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes operation, angle (Q4.28) and
//   tolerance; one request gives one result on the output channel
//   (out_valid/out_ready): value (Q12.28), term_count and two flags.
//   cfg_valid/cfg_ready writes term_limit; it is always ready. The user must
//   write it only while no request is in flight; the block does not check.
// Operation: every series term runs two chunked multiplies (16 x 32 bits
//   per cycle) and two restoring divides (2 quotient bits per cycle);
//   tangent adds the cosine series and a divide for its quotient. One
//   request is worked on at a time; in_ready is high only while the
//   sequencer is idle.
// Reset: sequencer idles, output empty, term_limit returns to 1000.
// Stall: the result waits in the output register; the next request can be
//   accepted meanwhile and its result waits for the register to drain.
// ----------------------------------------------------------------------------
module sin_cos_tan_taylor_series import sctt_pkg::*; #(
  parameter int FRAC_BITS      = 28,
  parameter int MAX_TERM_LIMIT = 1023
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_W-1:0]        term_limit,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         operation,
  input  logic signed [ANG_W-1:0] angle,
  input  logic [TOL_W-1:0]        tolerance,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] value,
  output logic [CNT_W-1:0]        term_count,
  output logic                    saturated,
  output logic                    limit_reached
);

  cmd_t             cmd;
  stat_t            stat;
  logic [CFG_W-1:0] limit_cfg;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      limit_cfg <= term_limit;
    end
  end

  sctt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sctt_dp #(
    .FRAC_BITS      (FRAC_BITS),
    .MAX_TERM_LIMIT (MAX_TERM_LIMIT)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .stat          (stat),
    .operation     (operation),
    .angle         (angle),
    .tolerance     (tolerance),
    .limit_cfg     (limit_cfg),
    .value         (value),
    .term_count    (term_count),
    .saturated     (saturated),
    .limit_reached (limit_reached)
  );

  // a request occupies the sequencer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // stopping on the limit always reports a nonzero count
  a_limit_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && limit_reached |-> term_count != '0)
    else $error("limit reached with zero term count");

  // a zero count only comes from the unused code, which raises no flag
  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && term_count == '0 |-> !saturated && !limit_reached)
    else $error("flags set on an unused operation");

endmodule
